### src/tvs_pkg.sv
// tvs_pkg: widths, register indexes, control structs and helpers shared by
// the tilt to velocity shaper modules. No dependencies.
`default_nettype none

package tvs_pkg;

   // field and datapath widths
   localparam int ANG_W    = 17;   // signed Q3.14 angle
   localparam int VEL_W    = 17;   // signed Q3.14 velocity
   localparam int CFG_W    = 16;
   localparam int MASK_W   = 3;
   localparam int IDX_W    = 3;    // csr register index
   localparam int AXES     = 3;
   localparam int AX_W     = 2;
   localparam int OP_W     = 20;   // multiplier operand magnitude
   localparam int PROD_W   = 2 * OP_W;
   localparam int ACC_W    = 44;   // signed accumulator
   localparam int SQ_W     = 42;   // radicand / dividend
   localparam int ROOT_W   = 21;   // root and divisor
   localparam int REM_W    = ROOT_W + 1;
   localparam int VEC_W    = 23;   // signed working vector element
   localparam int QUO_W    = 18;   // quotient bits of a scale divide
   localparam int RAW_W    = 18;   // scaled angle magnitude
   localparam int SUM_W    = 21;   // blended magnitude
   localparam int CNT_W    = 5;
   localparam int SQRT_STEPS = SQ_W / 2;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_AXIS_GAIN     = 3'd0;
   localparam logic [IDX_W-1:0] CSR_INVERT_MASK   = 3'd1;
   localparam logic [IDX_W-1:0] CSR_DEAD_BAND     = 3'd2;
   localparam logic [IDX_W-1:0] CSR_SMOOTH_WEIGHT = 3'd3;
   localparam logic [IDX_W-1:0] CSR_MAX_STEP      = 3'd4;
   localparam logic [IDX_W-1:0] CSR_MAX_SPEED     = 3'd5;

   // register reset values
   localparam logic [CFG_W-1:0]  RST_AXIS_GAIN     = 16'd13107;
   localparam logic [MASK_W-1:0] RST_INVERT_MASK   = 3'd6;
   localparam logic [CFG_W-1:0]  RST_DEAD_BAND     = 16'd82;
   localparam logic [CFG_W-1:0]  RST_SMOOTH_WEIGHT = 16'd19661;
   localparam logic [CFG_W-1:0]  RST_MAX_STEP      = 16'd328;
   localparam logic [CFG_W-1:0]  RST_MAX_SPEED     = 16'd4915;

   // invert mask bit positions
   localparam int INV_ROLL  = 0;
   localparam int INV_PITCH = 1;
   localparam int INV_YAW   = 2;

   typedef struct packed {
      logic issue;
      logic clear;
      logic neg;
   } mul_ctl_type;

   typedef enum logic {
      RD_SQRT,
      RD_DIV
   } rd_mode_type;

   typedef struct packed {
      logic        start;
      rd_mode_type mode;
   } rd_ctl_type;

   function automatic logic [ANG_W-1:0] mag17(input logic signed [ANG_W-1:0] v);
      mag17 = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
   endfunction

   function automatic logic [VEC_W-1:0] mag23(input logic signed [VEC_W-1:0] v);
      mag23 = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
   endfunction

   function automatic logic [ACC_W-1:0] mag44(input logic signed [ACC_W-1:0] v);
      mag44 = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
   endfunction

endpackage

`default_nettype wire

### src/tvs_mul_acc.sv
// tvs_mul_acc: shared multiplier with a signed accumulator behind it.
// Product registered, accumulated in the cycle after. Uses tvs_pkg.
`default_nettype none

module tvs_mul_acc (
   input  logic                              clock,
   input  logic                              reset,
   input  tvs_pkg::mul_ctl_type              ctl,
   input  logic [tvs_pkg::OP_W-1:0]          op_a,
   input  logic [tvs_pkg::OP_W-1:0]          op_b,
   output logic signed [tvs_pkg::ACC_W-1:0]  acc
);

   logic [tvs_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic                              issue_ff, clear_ff, neg_ff;
   logic signed [tvs_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [tvs_pkg::ACC_W-1:0]  base, term;

   // multiply stage
   assign prod_in = op_a * op_b;

   // accumulate stage
   always_comb begin
      base = clear_ff ? '0 : acc_ff;
      term = $signed({{(tvs_pkg::ACC_W - tvs_pkg::PROD_W){1'b0}}, prod_ff});
      if (issue_ff) begin
         acc_in = neg_ff ? base - term : base + term;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         clear_ff <= 1'b0;
         neg_ff   <= 1'b0;
      end else begin
         issue_ff <= ctl.issue;
         clear_ff <= ctl.clear;
         neg_ff   <= ctl.neg;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

### src/tvs_root_div.sv
// tvs_root_div: iterative rounded square root and restoring divide that
// share one subtractor, one bit per cycle. Uses tvs_pkg.
`default_nettype none

module tvs_root_div (
   input  logic                          clock,
   input  logic                          reset,
   input  tvs_pkg::rd_ctl_type           ctl,
   input  logic [tvs_pkg::SQ_W-1:0]      opnd,
   input  logic [tvs_pkg::ROOT_W-1:0]    dvsr,
   output logic                          done,
   output logic [tvs_pkg::ROOT_W-1:0]    result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX
   } state_type;

   localparam logic [tvs_pkg::SQ_W-1:0] BIT_TOP = tvs_pkg::SQ_W'(1) << (tvs_pkg::SQ_W - 2);

   state_type                     state_ff, state_in;
   tvs_pkg::rd_mode_type          mode_ff, mode_in;
   logic [tvs_pkg::SQ_W-1:0]      x_ff, x_in;
   logic [tvs_pkg::SQ_W-1:0]      r_ff, r_in;
   logic [tvs_pkg::SQ_W-1:0]      bit_ff, bit_in;
   logic [tvs_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [tvs_pkg::ROOT_W-1:0]    dvsr_ff, dvsr_in;
   logic [tvs_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          done_ff, done_in;

   logic [tvs_pkg::REM_W-1:0]     t;
   logic [tvs_pkg::SQ_W:0]        sub_a, sub_b, diff;
   logic                          ge;

   // shared subtractor
   always_comb begin
      t = {rem_ff[tvs_pkg::REM_W-2:0], x_ff[tvs_pkg::QUO_W-1]};
      if (mode_ff == tvs_pkg::RD_SQRT) begin
         sub_a = {1'b0, x_ff};
         sub_b = {1'b0, r_ff + bit_ff};
      end else begin
         sub_a = {{(tvs_pkg::SQ_W + 1 - tvs_pkg::REM_W){1'b0}}, t};
         sub_b = {{(tvs_pkg::SQ_W + 1 - tvs_pkg::ROOT_W){1'b0}}, dvsr_ff};
      end
      diff = sub_a - sub_b;
      ge   = ~diff[tvs_pkg::SQ_W];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               mode_in  = ctl.mode;
               x_in     = opnd;
               r_in     = '0;
               bit_in   = BIT_TOP;
               rem_in   = opnd[tvs_pkg::QUO_W + tvs_pkg::REM_W - 1:tvs_pkg::QUO_W];
               dvsr_in  = dvsr;
               state_in = ST_RUN;
               if (ctl.mode == tvs_pkg::RD_SQRT) begin
                  cnt_in = tvs_pkg::CNT_W'(tvs_pkg::SQRT_STEPS - 1);
               end else begin
                  cnt_in = tvs_pkg::CNT_W'(tvs_pkg::QUO_W - 1);
               end
            end
         end
         ST_RUN: begin
            if (mode_ff == tvs_pkg::RD_SQRT) begin
               if (ge) begin
                  x_in = diff[tvs_pkg::SQ_W-1:0];
                  r_in = (r_ff >> 1) + bit_ff;
               end else begin
                  r_in = r_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else begin
               rem_in = ge ? diff[tvs_pkg::REM_W-1:0] : t;
               r_in   = {r_ff[tvs_pkg::SQ_W-2:0], ge};
               x_in   = x_ff << 1;
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (mode_ff == tvs_pkg::RD_SQRT) begin
                  state_in = ST_FIX;
               end else begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIX: begin
            // round the root to nearest
            if (x_ff > r_ff) begin
               r_in = r_ff + 1'b1;
            end
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         mode_ff  <= tvs_pkg::RD_SQRT;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         mode_ff  <= mode_in;
      end
      x_ff    <= x_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = r_ff[tvs_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

### src/tilt_to_velocity_shaper_top.sv
// tilt_to_velocity_shaper_top: sequencer, configuration registers and state
// of the shaper. Depends on tvs_pkg, tvs_mul_acc and tvs_root_div.
`default_nettype none

// Turns one tick of tilt angles into a velocity command: gain, per-axis sign
// inversion, deadzone, exponential blend with the stored velocity, a step
// limit and a speed limit, both by vector norm. One tick is worked at a time;
// req_ready is high only while the block is idle. All multiplies, square roots
// and divides run through one shared multiply-accumulate unit and one
// bit-serial root/divide unit; each engaged limit adds a square root and
// three scale divides to a valid tick. An invalid tick clears the stored
// velocity. A finished result waits in the output register, and the
// next tick is taken while it waits.
module tilt_to_velocity_shaper_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_tilt_valid,
   input  logic signed [tvs_pkg::ANG_W-1:0]    req_pitch_angle,
   input  logic signed [tvs_pkg::ANG_W-1:0]    req_roll_angle,
   input  logic signed [tvs_pkg::ANG_W-1:0]    req_yaw_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tvs_pkg::VEL_W-1:0]    rsp_vel_x,
   output logic signed [tvs_pkg::VEL_W-1:0]    rsp_vel_y,
   output logic signed [tvs_pkg::VEL_W-1:0]    rsp_vel_z,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tvs_pkg::IDX_W-1:0]           csr_index,
   input  logic [tvs_pkg::CFG_W-1:0]           csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_RAW,
      S_DZ,
      S_BL1,
      S_BL2,
      S_SUM,
      S_LIM,
      S_LIMQ,
      S_SQ,
      S_CMP,
      S_ROOT,
      S_SCL,
      S_DIV,
      S_DIVW,
      S_APPLY,
      S_SAT,
      S_OUT,
      S_WAIT
   } state_type;

   localparam logic [tvs_pkg::AX_W-1:0] LAST_AX = tvs_pkg::AX_W'(tvs_pkg::AXES - 1);

   // configuration registers
   logic [tvs_pkg::CFG_W-1:0]   gain_ff, band_ff, weight_ff, step_ff, speed_ff;
   logic [tvs_pkg::MASK_W-1:0]  inv_ff;

   // sequencer state and working registers
   state_type                          state_ff, state_in;
   state_type                          ret_ff, ret_in;
   logic [tvs_pkg::AX_W-1:0]           idx_ff, idx_in;
   logic                               phase_ff, phase_in;
   logic signed [tvs_pkg::ANG_W-1:0]   ang_ff [tvs_pkg::AXES];
   logic signed [tvs_pkg::ANG_W-1:0]   ang_in [tvs_pkg::AXES];
   logic signed [tvs_pkg::VEL_W-1:0]   last_ff [tvs_pkg::AXES];
   logic signed [tvs_pkg::VEL_W-1:0]   last_in [tvs_pkg::AXES];
   logic signed [tvs_pkg::VEC_W-1:0]   vec_ff [tvs_pkg::AXES];
   logic signed [tvs_pkg::VEC_W-1:0]   vec_in [tvs_pkg::AXES];
   logic [tvs_pkg::RAW_W-1:0]          dz_mag_ff, dz_mag_in;
   logic                               dz_neg_ff, dz_neg_in;
   logic [2*tvs_pkg::CFG_W-1:0]        limsq_ff, limsq_in;
   logic [tvs_pkg::ROOT_W-1:0]         n_ff, n_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [tvs_pkg::VEL_W-1:0]   rsp_x_ff, rsp_x_in;
   logic signed [tvs_pkg::VEL_W-1:0]   rsp_y_ff, rsp_y_in;
   logic signed [tvs_pkg::VEL_W-1:0]   rsp_z_ff, rsp_z_in;

   // unit connections
   tvs_pkg::mul_ctl_type               mul_ctl;
   logic [tvs_pkg::OP_W-1:0]           op_a, op_b;
   logic signed [tvs_pkg::ACC_W-1:0]   acc;
   tvs_pkg::rd_ctl_type                rd_ctl;
   logic [tvs_pkg::SQ_W-1:0]           rd_opnd;
   logic                               rd_done;
   logic [tvs_pkg::ROOT_W-1:0]         rd_result;

   // datapath temporaries
   logic [tvs_pkg::CFG_W-1:0]          lim;
   logic [tvs_pkg::CFG_W:0]            alpha;
   logic                               inv_bit;
   logic [32:0]                        raw_sum;
   logic [tvs_pkg::RAW_W-1:0]          raw_mag;
   logic [tvs_pkg::ACC_W-1:0]          acc_mag;
   logic [36:0]                        blend_sum;
   logic [tvs_pkg::SUM_W-1:0]          s_mag;
   logic signed [tvs_pkg::VEC_W-1:0]   s_val;
   logic [tvs_pkg::PROD_W-1:0]         div_num;
   logic [tvs_pkg::QUO_W-1:0]          quo;

   function automatic logic signed [tvs_pkg::VEL_W-1:0] sat_vel(
      input logic signed [tvs_pkg::VEC_W-1:0] v);
      if (v > $signed(tvs_pkg::VEC_W'(65535))) begin
         sat_vel = tvs_pkg::VEL_W'(65535);
      end else if (v < -$signed(tvs_pkg::VEC_W'(65536))) begin
         sat_vel = {1'b1, {(tvs_pkg::VEL_W-1){1'b0}}};
      end else begin
         sat_vel = v[tvs_pkg::VEL_W-1:0];
      end
   endfunction

   // shared units
   tvs_mul_acc u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   tvs_root_div u_rd (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rd_ctl),
      .opnd   (rd_opnd),
      .dvsr   (n_ff),
      .done   (rd_done),
      .result (rd_result)
   );

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= tvs_pkg::RST_AXIS_GAIN;
         inv_ff    <= tvs_pkg::RST_INVERT_MASK;
         band_ff   <= tvs_pkg::RST_DEAD_BAND;
         weight_ff <= tvs_pkg::RST_SMOOTH_WEIGHT;
         step_ff   <= tvs_pkg::RST_MAX_STEP;
         speed_ff  <= tvs_pkg::RST_MAX_SPEED;
      end else if (csr_valid) begin
         case (csr_index)
            tvs_pkg::CSR_AXIS_GAIN:     gain_ff   <= csr_wdata;
            tvs_pkg::CSR_INVERT_MASK:   inv_ff    <= csr_wdata[tvs_pkg::MASK_W-1:0];
            tvs_pkg::CSR_DEAD_BAND:     band_ff   <= csr_wdata;
            tvs_pkg::CSR_SMOOTH_WEIGHT: weight_ff <= csr_wdata;
            tvs_pkg::CSR_MAX_STEP:      step_ff   <= csr_wdata;
            tvs_pkg::CSR_MAX_SPEED:     speed_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // fixed datapath pieces
   always_comb begin
      lim   = phase_ff ? speed_ff : step_ff;
      alpha = (tvs_pkg::CFG_W+1)'(1 << tvs_pkg::CFG_W) - {1'b0, weight_ff};
      case (idx_ff)
         2'd0:    inv_bit = inv_ff[tvs_pkg::INV_PITCH];
         2'd1:    inv_bit = inv_ff[tvs_pkg::INV_ROLL];
         default: inv_bit = inv_ff[tvs_pkg::INV_YAW];
      endcase
      // round half away from zero of gain product over 2^14
      raw_sum   = acc[32:0] + 33'd8192;
      raw_mag   = raw_sum[31:14];
      // blend rounded over 2^16
      acc_mag   = tvs_pkg::mag44(acc);
      blend_sum = acc_mag[36:0] + 37'd32768;
      s_mag     = blend_sum[36:16];
      s_val     = acc[tvs_pkg::ACC_W-1] ? -$signed({2'b00, s_mag}) : $signed({2'b00, s_mag});
      div_num   = acc[tvs_pkg::PROD_W-1:0]
                  + {{(tvs_pkg::PROD_W - tvs_pkg::ROOT_W + 1){1'b0}},
                     n_ff[tvs_pkg::ROOT_W-1:1]};
      quo       = rd_result[tvs_pkg::QUO_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      ang_in       = ang_ff;
      last_in      = last_ff;
      vec_in       = vec_ff;
      dz_mag_in    = dz_mag_ff;
      dz_neg_in    = dz_neg_ff;
      limsq_in     = limsq_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      mul_ctl      = '0;
      op_a         = '0;
      op_b         = '0;
      rd_ctl       = '{start: 1'b0, mode: tvs_pkg::RD_SQRT};
      rd_opnd      = acc[tvs_pkg::SQ_W-1:0];
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ang_in[0] = req_pitch_angle;
               ang_in[1] = req_roll_angle;
               ang_in[2] = req_yaw_angle;
               idx_in    = '0;
               if (req_tilt_valid) begin
                  state_in = S_RAW;
               end else begin
                  for (int i = 0; i < tvs_pkg::AXES; i++) begin
                     last_in[i] = '0;
                  end
                  state_in = S_OUT;
               end
            end
         end
         // gain product of one axis
         S_RAW: begin
            mul_ctl  = '{issue: 1'b1, clear: 1'b1, neg: 1'b0};
            op_a     = tvs_pkg::OP_W'(tvs_pkg::mag17(ang_ff[idx_ff]));
            op_b     = tvs_pkg::OP_W'(gain_ff);
            ret_in   = S_DZ;
            state_in = S_WAIT;
         end
         // deadzone on the rounded, signed raw value
         S_DZ: begin
            dz_neg_in = ang_ff[idx_ff][tvs_pkg::ANG_W-1] ^ inv_bit;
            if (raw_mag < tvs_pkg::RAW_W'(band_ff)) begin
               dz_mag_in = '0;
            end else begin
               dz_mag_in = raw_mag - tvs_pkg::RAW_W'(band_ff);
            end
            state_in = S_BL1;
         end
         S_BL1: begin
            mul_ctl  = '{issue: 1'b1, clear: 1'b1, neg: dz_neg_ff};
            op_a     = tvs_pkg::OP_W'(dz_mag_ff);
            op_b     = tvs_pkg::OP_W'(alpha);
            state_in = S_BL2;
         end
         S_BL2: begin
            mul_ctl  = '{issue: 1'b1, clear: 1'b0,
                         neg: last_ff[idx_ff][tvs_pkg::VEL_W-1]};
            op_a     = tvs_pkg::OP_W'(tvs_pkg::mag17(last_ff[idx_ff]));
            op_b     = tvs_pkg::OP_W'(weight_ff);
            ret_in   = S_SUM;
            state_in = S_WAIT;
         end
         // change from the stored velocity
         S_SUM: begin
            vec_in[idx_ff] = s_val - tvs_pkg::VEC_W'(last_ff[idx_ff]);
            if (idx_ff == LAST_AX) begin
               idx_in   = '0;
               phase_in = 1'b0;
               state_in = S_LIM;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RAW;
            end
         end
         // limit squared
         S_LIM: begin
            mul_ctl  = '{issue: 1'b1, clear: 1'b1, neg: 1'b0};
            op_a     = tvs_pkg::OP_W'(lim);
            op_b     = tvs_pkg::OP_W'(lim);
            ret_in   = S_LIMQ;
            state_in = S_WAIT;
         end
         S_LIMQ: begin
            limsq_in = acc[2*tvs_pkg::CFG_W-1:0];
            idx_in   = '0;
            state_in = S_SQ;
         end
         // squared norm of the working vector
         S_SQ: begin
            mul_ctl = '{issue: 1'b1, clear: (idx_ff == '0), neg: 1'b0};
            op_a    = tvs_pkg::OP_W'(tvs_pkg::mag23(vec_ff[idx_ff]));
            op_b    = tvs_pkg::OP_W'(tvs_pkg::mag23(vec_ff[idx_ff]));
            if (idx_ff == LAST_AX) begin
               idx_in   = '0;
               ret_in   = S_CMP;
               state_in = S_WAIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CMP: begin
            if (acc[tvs_pkg::SQ_W-1:0] > tvs_pkg::SQ_W'(limsq_ff)) begin
               rd_ctl   = '{start: 1'b1, mode: tvs_pkg::RD_SQRT};
               state_in = S_ROOT;
            end else begin
               state_in = phase_ff ? S_SAT : S_APPLY;
            end
         end
         S_ROOT: begin
            if (rd_done) begin
               n_in     = rd_result;
               idx_in   = '0;
               state_in = S_SCL;
            end
         end
         // scale one element by lim / norm
         S_SCL: begin
            mul_ctl  = '{issue: 1'b1, clear: 1'b1, neg: 1'b0};
            op_a     = tvs_pkg::OP_W'(tvs_pkg::mag23(vec_ff[idx_ff]));
            op_b     = tvs_pkg::OP_W'(lim);
            ret_in   = S_DIV;
            state_in = S_WAIT;
         end
         S_DIV: begin
            rd_ctl   = '{start: 1'b1, mode: tvs_pkg::RD_DIV};
            rd_opnd  = tvs_pkg::SQ_W'(div_num);
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (rd_done) begin
               if (vec_ff[idx_ff][tvs_pkg::VEC_W-1]) begin
                  vec_in[idx_ff] = -$signed(tvs_pkg::VEC_W'(quo));
               end else begin
                  vec_in[idx_ff] = $signed(tvs_pkg::VEC_W'(quo));
               end
               if (idx_ff == LAST_AX) begin
                  idx_in   = '0;
                  state_in = phase_ff ? S_SAT : S_APPLY;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SCL;
               end
            end
         end
         // new velocity from the limited change
         S_APPLY: begin
            for (int i = 0; i < tvs_pkg::AXES; i++) begin
               vec_in[i] = tvs_pkg::VEC_W'(last_ff[i]) + vec_ff[i];
            end
            phase_in = 1'b1;
            state_in = S_LIM;
         end
         S_SAT: begin
            for (int i = 0; i < tvs_pkg::AXES; i++) begin
               last_in[i] = sat_vel(vec_ff[i]);
            end
            state_in = S_OUT;
         end
         // hand the result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = last_ff[0];
               rsp_y_in     = last_ff[1];
               rsp_z_in     = last_ff[2];
               state_in     = S_IDLE;
            end
         end
         S_WAIT: begin
            state_in = ret_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         idx_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < tvs_pkg::AXES; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
      ang_ff    <= ang_in;
      vec_ff    <= vec_in;
      dz_mag_ff <= dz_mag_in;
      dz_neg_ff <= dz_neg_in;
      limsq_ff  <= limsq_in;
      n_ff      <= n_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_z_ff  <= rsp_z_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vel_x = rsp_x_ff;
   assign rsp_vel_y = rsp_y_ff;
   assign rsp_vel_z = rsp_z_ff;

endmodule

`default_nettype wire

### src/tvs_checker.sv
// tvs_checker: port-level checks of the shaper top level, bound to it.
// Depends on tvs_pkg and tilt_to_velocity_shaper_top.
`default_nettype none

module tvs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [tvs_pkg::VEL_W-1:0]  rsp_vel_x,
   input logic signed [tvs_pkg::VEL_W-1:0]  rsp_vel_y,
   input logic signed [tvs_pkg::VEL_W-1:0]  rsp_vel_z,
   input logic                              csr_ready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vel_x)
         && $stable(rsp_vel_y) && $stable(rsp_vel_z))
      else $error("result changed while stalled");

   // one tick at a time: busy right after a transfer in
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after input transfer");

   // a new result comes only out of a busy cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

   // configuration is always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port stalled");

endmodule

bind tilt_to_velocity_shaper_top tvs_checker u_tvs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_vel_x (rsp_vel_x),
   .rsp_vel_y (rsp_vel_y),
   .rsp_vel_z (rsp_vel_z),
   .csr_ready (csr_ready)
);

`default_nettype wire
